@@ design/cse_pkg.sv @@
// cse_pkg: shared constants and types for the cycle sort engine
// no dependencies
package cse_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic  insert;
    logic  shift;
    data_t key;
  } cse_ctrl_t;

  localparam logic ST_COLLECT = 1'b0;
  localparam logic ST_EMIT    = 1'b1;

endpackage

@@ design/cse_in_if.sv @@
// cse_in_if: input channel of the cycle sort engine
// depends on cse_pkg
interface cse_in_if import cse_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t value;
  logic  last_in;

  modport source (output valid, output value, output last_in, input ready);
  modport sink   (input valid, input value, input last_in, output ready);
endinterface

@@ design/cse_out_if.sv @@
// cse_out_if: result channel of the cycle sort engine
// depends on cse_pkg
interface cse_out_if import cse_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t sorted_value;
  logic  last_out;
  logic  overflow;

  modport source (output valid, output sorted_value, output last_out, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input overflow,
                  output ready);
endinterface

@@ design/cycle_sort_engine.sv @@
// cycle_sort_engine: sorts a marked set of signed words ascending, then streams it out
// timing: a word that fits takes its slot in the next cycle; after the last word the
//   first result is offered in the next cycle, then one per cycle while ready, n in all
// throughput: one input word per cycle while collecting, set size set by the 64-cell chain
// reset: synchronous, clears slot occupancy, overflow flag and the collect/emit state
module cycle_sort_engine import cse_pkg::*; (
  input logic clk,
  input logic rst,
  cse_in_if.sink    din,
  cse_out_if.source dout
);

  logic      state;
  logic      state_next;
  logic      overflow_flag;
  logic      overflow_flag_next;
  cse_ctrl_t ctrl;
  logic      in_acc;
  logic      out_acc;
  logic      full;

  data_t vals [MAX_ELEMENTS];
  logic  occs [MAX_ELEMENTS];
  logic  gts  [MAX_ELEMENTS];

  assign din.ready = (state == ST_COLLECT);
  assign in_acc    = din.valid && din.ready;
  assign out_acc   = dout.valid && dout.ready;
  assign full      = occs[MAX_ELEMENTS-1];

  assign ctrl.insert = in_acc && !full;
  assign ctrl.shift  = out_acc;
  assign ctrl.key    = din.value;

  genvar g;
  generate
    for (g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
      data_t lv;
      logic  lo;
      logic  lg;
      data_t rv;
      logic  ro;
      if (g == 0) begin : g_first
        assign lv = '0;
        assign lo = 1'b1;
        assign lg = 1'b0;
      end else begin : g_mid
        assign lv = vals[g-1];
        assign lo = occs[g-1];
        assign lg = gts[g-1];
      end
      if (g == MAX_ELEMENTS-1) begin : g_end
        assign rv = '0;
        assign ro = 1'b0;
      end else begin : g_inner
        assign rv = vals[g+1];
        assign ro = occs[g+1];
      end
      cse_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .left_val  (lv),
        .left_occ  (lo),
        .left_gt   (lg),
        .right_val (rv),
        .right_occ (ro),
        .val       (vals[g]),
        .occ       (occs[g]),
        .gt        (gts[g])
      );
    end
  endgenerate

  assign dout.valid        = (state == ST_EMIT);
  assign dout.sorted_value = vals[0];
  assign dout.last_out     = !occs[1];
  assign dout.overflow     = overflow_flag;

  always_comb begin
    state_next         = state;
    overflow_flag_next = overflow_flag;
    unique case (state)
      ST_COLLECT: begin
        if (in_acc) begin
          if (full) begin
            overflow_flag_next = 1'b1;
          end
          if (din.last_in) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_acc && !occs[1]) begin
          state_next         = ST_COLLECT;
          overflow_flag_next = 1'b0;
        end
      end
      default: begin
        state_next = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_COLLECT;
      overflow_flag <= 1'b0;
    end else begin
      state         <= state_next;
      overflow_flag <= overflow_flag_next;
    end
  end

endmodule

@@ design/cse_cell.sv @@
// cse_cell: one slot of the sorting chain, keeps its value ordered against its neighbors
// depends on cse_pkg
module cse_cell import cse_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cse_ctrl_t ctrl,
  input  data_t     left_val,
  input  logic      left_occ,
  input  logic      left_gt,
  input  data_t     right_val,
  input  logic      right_occ,
  output data_t     val,
  output logic      occ,
  output logic      gt
);

  // empty slot acts as plus infinity
  assign gt = !occ || ($signed(ctrl.key) < $signed(val));

  always_ff @(posedge clk) begin
    if (ctrl.insert && gt) begin
      val <= left_gt ? left_val : ctrl.key;
    end else if (ctrl.shift) begin
      val <= right_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctrl.insert) begin
      occ <= occ | left_occ;
    end else if (ctrl.shift) begin
      occ <= right_occ;
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// testbench: checks cycle_sort_engine against an in-bench sorter on directed and random sets
// depends on cse_pkg, cse_in_if, cse_out_if and cycle_sort_engine
module testbench;
  import cse_pkg::*;

  typedef struct {
    data_t sorted_value;
    logic  last_out;
    logic  overflow;
  } sorted_word_t;

  localparam data_t WORD_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
  localparam data_t WORD_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t WORD_ZERO = '0;
  localparam data_t WORD_NEG1 = '1;
  localparam int    REPORT_MAX = 10;

  logic clk;
  logic rst;

  cse_in_if  word_in();
  cse_out_if word_out();

  cycle_sort_engine DUT (
    .clk  (clk),
    .rst  (rst),
    .din  (word_in),
    .dout (word_out)
  );

  data_t        collected[$];
  logic         collected_overflow;
  sorted_word_t sorted_due[$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatch_count;
  int words_sent;
  int sets_sent;
  int overflow_sets;
  int results_checked;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic void sort_collected();
    int i;
    int j;
    data_t held;
    sorted_word_t w;
    for (i = 1; i < collected.size(); i++) begin
      held = collected[i];
      j = i;
      while (j > 0 && collected[j-1] > held) begin
        collected[j] = collected[j-1];
        j--;
      end
      collected[j] = held;
    end
    for (i = 0; i < collected.size(); i++) begin
      w.sorted_value = collected[i];
      w.last_out     = (i == collected.size() - 1);
      w.overflow     = collected_overflow;
      sorted_due.push_back(w);
    end
  endfunction

  function automatic void accept_word(data_t v, logic last);
    if (collected.size() < MAX_ELEMENTS) begin
      collected.push_back(v);
    end else begin
      collected_overflow = 1'b1;
    end
    if (last) begin
      sort_collected();
      sets_sent++;
      if (collected_overflow) begin
        overflow_sets++;
      end
      collected.delete();
      collected_overflow = 1'b0;
    end
  endfunction

  task automatic send_word(input data_t v, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      word_in.valid <= 1'b0;
      @(posedge clk);
    end
    word_in.valid   <= 1'b1;
    word_in.value   <= v;
    word_in.last_in <= last;
    do @(posedge clk); while (!word_in.ready);
    accept_word(v, last);
    words_sent++;
  endtask

  task automatic wait_drained();
    word_in.valid <= 1'b0;
    do @(posedge clk); while (sorted_due.size() != 0);
  endtask

  function automatic data_t rand_value();
    data_t v;
    case ($urandom_range(0, 3))
      0: v = data_t'($urandom_range(0, 15)) - 8;
      1: begin
        case ($urandom_range(0, 3))
          0: v = WORD_MIN;
          1: v = WORD_MAX;
          2: v = WORD_ZERO;
          default: v = WORD_NEG1;
        endcase
      end
      default: v = data_t'($urandom);
    endcase
    return v;
  endfunction

  // initial checker and result-side backpressure
  initial begin
    sorted_word_t w;
    word_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && word_out.valid && word_out.ready) begin
        results_checked++;
        if (sorted_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("unexpected word: value %0d last %b overflow %b",
                     word_out.sorted_value, word_out.last_out, word_out.overflow);
          end
        end else begin
          w = sorted_due.pop_front();
          if (w.sorted_value !== word_out.sorted_value || w.last_out !== word_out.last_out ||
              w.overflow !== word_out.overflow) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
              $display("mismatch: expected value %0d last %b overflow %b, got %0d %b %b",
                       w.sorted_value, w.last_out, w.overflow,
                       word_out.sorted_value, word_out.last_out, word_out.overflow);
            end
          end
        end
      end
      word_out.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic test_extremes();
    send_word(WORD_MIN, 1'b1);
    send_word(WORD_MAX, 1'b1);
    send_word(WORD_ZERO, 1'b1);
    send_word(WORD_NEG1, 1'b1);
    send_word(WORD_MAX, 1'b0);
    send_word(WORD_NEG1, 1'b0);
    send_word(WORD_MIN, 1'b0);
    send_word(WORD_ZERO, 1'b0);
    send_word(data_t'(1), 1'b1);
  endtask

  task automatic test_duplicates();
    int i;
    for (i = 0; i < 4; i++) begin
      send_word(data_t'(-5), i == 3);
    end
    send_word(data_t'(3), 1'b0);
    send_word(data_t'(-2), 1'b0);
    send_word(data_t'(3), 1'b0);
    send_word(WORD_MIN, 1'b0);
    send_word(data_t'(-2), 1'b1);
  endtask

  task automatic test_order();
    int i;
    for (i = 0; i < 4; i++) begin
      send_word(data_t'(i * 100 - 150), i == 3);
    end
    for (i = 0; i < 3; i++) begin
      send_word(data_t'(1000 - i * 700), i == 2);
    end
  endtask

  // a full store, then one word past it with the last word dropped
  task automatic test_capacity();
    int i;
    wait_drained();
    for (i = 0; i <= MAX_ELEMENTS; i++) begin
      send_word(rand_value(), i == MAX_ELEMENTS);
    end
  endtask

  task automatic test_random(input int n_words);
    int sent;
    int set_size;
    int i;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(0, 99) < 90) begin
        set_size = $urandom_range(1, 8);
      end else begin
        set_size = $urandom_range(9, 24);
      end
      for (i = 0; i < set_size; i++) begin
        send_word(rand_value(), i == set_size - 1);
      end
      sent += set_size;
    end
  endtask

  initial begin
    rst                <= 1'b1;
    word_in.valid      <= 1'b0;
    word_in.value      <= '0;
    word_in.last_in    <= 1'b0;
    collected_overflow = 1'b0;
    mismatch_count     = 0;
    words_sent         = 0;
    sets_sent          = 0;
    overflow_sets      = 0;
    results_checked    = 0;
    send_idle_pct      = 12;
    recv_stall_pct     = 65;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_extremes();
    test_duplicates();
    test_order();
    test_capacity();
    test_random(6);
    send_idle_pct  = 65;
    recv_stall_pct = 12;
    test_random(6);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random(6);

    wait_drained();
    repeat (8) @(posedge clk);
    if (sorted_due.size() != 0) begin
      mismatch_count++;
      $display("%0d sorted words never arrived", sorted_due.size());
    end
    $display("sent %0d words in %0d sets (%0d overflowed), checked %0d sorted words",
             words_sent, sets_sent, overflow_sets, results_checked);
    $display("mismatches: %0d", mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/cse_pkg.sv
design/cse_in_if.sv
design/cse_out_if.sv
design/cse_cell.sv
design/cycle_sort_engine.sv
tb/sv/testbench.sv
